// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Implication checks shared by the RTL; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/smsd_pkg.sv =====
// ----------------------------------------------------------------------------
// smsd_pkg
// Types and constants shared by the sliding minimum squared distance core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smsd_pkg;

   localparam int REQ_DATA_W = 16;
   localparam int SUM_WIDTH  = 48;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [SUM_WIDTH-1:0]  SUM_MAX          = '1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CENTRED_ADDR = 3'd0;

   localparam logic OP_FIRST  = 1'b0;
   localparam logic OP_SECOND = 1'b1;

   // pipeline depth from the last read issue to the final best update
   localparam int DRAIN_CYCLES = 4;
   localparam int DRAIN_W      = 2;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic wr_first;
      logic wr_second;
      logic rd_valid;
      logic rd_first;
      logic rd_last;
      logic rd_swap;
      logic clear_best;
      logic load_result;
      logic result_zero;
      logic result_overflow;
   } dp_cmd_type;

endpackage

`default_nettype wire

// ===== src/smsd_regs.sv =====
// ----------------------------------------------------------------------------
// smsd_regs
// Configuration register block on the APB-style port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smsd_regs (
   input  wire  logic                                 clock,
   input  wire  logic                                 reset,
   input  wire  logic                                 csr_psel,
   input  wire  logic                                 csr_penable,
   input  wire  logic                                 csr_pwrite,
   input  wire  logic [smsd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire  logic [smsd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic       [smsd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                       csr_pready,
   output logic                                       centred_mode
);
   import smsd_pkg::*;

   logic centred_ff;
   logic centred_in;
   logic hit;

   assign hit        = (csr_paddr == CSR_CENTRED_ADDR);
   assign csr_pready = 1'b1;

   always_comb begin
      centred_in = centred_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && hit) begin
         centred_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         centred_ff <= 1'b0;
      end else begin
         centred_ff <= centred_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (hit) begin
         csr_prdata[0] = centred_ff;
      end
   end

   assign centred_mode = centred_ff;

endmodule

`default_nettype wire

// ===== src/smsd_dp.sv =====
// ----------------------------------------------------------------------------
// smsd_dp
// Sample stores and the difference, square, accumulate and minimum pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smsd_dp #(
   parameter int MAX_LEN      = 1024,
   parameter int SAMPLE_WIDTH = 16,
   localparam int ADDR_W      = $clog2(MAX_LEN)
) (
   input  wire  logic                              clock,
   input  wire  logic                              reset,
   input  wire  smsd_pkg::dp_cmd_type              cmd,
   input  wire  logic [ADDR_W-1:0]                 wr_addr,
   input  wire  logic [SAMPLE_WIDTH-1:0]           wr_data,
   input  wire  logic [ADDR_W-1:0]                 rd_first_addr,
   input  wire  logic [ADDR_W-1:0]                 rd_second_addr,
   input  wire  logic                              centred_mode,
   output logic       [smsd_pkg::SUM_WIDTH-1:0]    min_distance,
   output logic                                    overflow
);
   import smsd_pkg::*;

   localparam int DIFF_W = SAMPLE_WIDTH + 1;
   localparam int D_W    = SAMPLE_WIDTH + 2;
   localparam int MAG_W  = SAMPLE_WIDTH + 1;
   localparam int SQ_W   = 2 * SAMPLE_WIDTH + 2;
   localparam int ACC_W  = ((SQ_W > SUM_WIDTH) ? SQ_W : SUM_WIDTH) + 1;

   logic [SAMPLE_WIDTH-1:0] first_mem  [MAX_LEN];
   logic [SAMPLE_WIDTH-1:0] second_mem [MAX_LEN];

   logic [SAMPLE_WIDTH-1:0] first_rd_ff;
   logic [SAMPLE_WIDTH-1:0] second_rd_ff;
   logic                    v1_ff, first1_ff, last1_ff, swap1_ff;

   logic signed [DIFF_W-1:0] diff;
   logic signed [DIFF_W-1:0] off_ff, off_in;
   logic signed [D_W-1:0]    d_ff, d_in;
   logic                     v2_ff, first2_ff, last2_ff;

   logic [D_W-1:0]   mag_full;
   logic [SQ_W-1:0]  mag_ext;
   logic [SQ_W-1:0]  sq_ff, sq_in;
   logic             v3_ff, first3_ff, last3_ff;

   logic [SUM_WIDTH-1:0] sum_ff, sum_in;
   logic [ACC_W-1:0]     acc_wide;
   logic                 done4_ff;

   logic [SUM_WIDTH-1:0] best_ff, best_in;
   logic [SUM_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                 rsp_user_ff, rsp_user_in;

   logic [SAMPLE_WIDTH-1:0] win, pat;

   // sample stores
   always_ff @(posedge clock) begin
      if (cmd.wr_first) begin
         first_mem[wr_addr] <= wr_data;
      end
      first_rd_ff <= first_mem[rd_first_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_second) begin
         second_mem[wr_addr] <= wr_data;
      end
      second_rd_ff <= second_mem[rd_second_addr];
   end

   // difference and offset removal
   always_comb begin
      win  = swap1_ff ? first_rd_ff : second_rd_ff;
      pat  = swap1_ff ? second_rd_ff : first_rd_ff;
      diff = $signed({win[SAMPLE_WIDTH-1], win}) - $signed({pat[SAMPLE_WIDTH-1], pat});
      off_in = off_ff;
      if (v1_ff && first1_ff) begin
         off_in = diff;
      end
      if (centred_mode) begin
         if (first1_ff) begin
            d_in = '0;
         end else begin
            d_in = $signed({diff[DIFF_W-1], diff}) - $signed({off_ff[DIFF_W-1], off_ff});
         end
      end else begin
         d_in = $signed({diff[DIFF_W-1], diff});
      end
   end

   // square
   always_comb begin
      mag_full = d_ff[D_W-1] ? D_W'(-d_ff) : D_W'(d_ff);
      mag_ext  = {{(SQ_W-MAG_W){1'b0}}, mag_full[MAG_W-1:0]};
      sq_in    = mag_ext * mag_ext;
   end

   // saturating accumulate
   always_comb begin
      acc_wide = (first3_ff ? '0 : {{(ACC_W-SUM_WIDTH){1'b0}}, sum_ff})
               + {{(ACC_W-SQ_W){1'b0}}, sq_ff};
      sum_in   = sum_ff;
      if (v3_ff) begin
         sum_in = (acc_wide >= ACC_W'(SUM_MAX)) ? SUM_MAX : acc_wide[SUM_WIDTH-1:0];
      end
   end

   // running minimum and result register
   always_comb begin
      best_in = best_ff;
      if (cmd.clear_best) begin
         best_in = SUM_MAX;
      end else if (done4_ff && (sum_ff < best_ff)) begin
         best_in = sum_ff;
      end
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      if (cmd.load_result) begin
         rsp_data_in = cmd.result_zero ? '0 : best_ff;
         rsp_user_in = cmd.result_overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         done4_ff <= 1'b0;
      end else begin
         v1_ff    <= cmd.rd_valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         done4_ff <= v3_ff && last3_ff;
      end
   end

   always_ff @(posedge clock) begin
      first1_ff   <= cmd.rd_first;
      last1_ff    <= cmd.rd_last;
      swap1_ff    <= cmd.rd_swap;
      off_ff      <= off_in;
      d_ff        <= d_in;
      first2_ff   <= first1_ff;
      last2_ff    <= last1_ff;
      sq_ff       <= sq_in;
      first3_ff   <= first2_ff;
      last3_ff    <= last2_ff;
      sum_ff      <= sum_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign min_distance = rsp_data_ff;
   assign overflow     = rsp_user_ff;

endmodule

`default_nettype wire

// ===== src/smsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// smsd_ctrl
// Load bookkeeping and the alignment scan sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module smsd_ctrl #(
   parameter int MAX_LEN = 1024,
   localparam int ADDR_W = $clog2(MAX_LEN),
   localparam int CNT_W  = $clog2(MAX_LEN + 1)
) (
   input  wire  logic                  clock,
   input  wire  logic                  reset,
   input  wire  logic                  req_tvalid,
   output logic                        req_tready,
   input  wire  logic                  req_op,
   input  wire  logic                  req_last,
   output logic                        rsp_tvalid,
   input  wire  logic                  rsp_tready,
   output smsd_pkg::dp_cmd_type        cmd,
   output logic [ADDR_W-1:0]           wr_addr,
   output logic [ADDR_W-1:0]           rd_first_addr,
   output logic [ADDR_W-1:0]           rd_second_addr
);
   import smsd_pkg::*;

   ctrl_state_type state_ff, state_in;

   logic [CNT_W-1:0]   first_cnt_ff, first_cnt_in;
   logic [CNT_W-1:0]   second_cnt_ff, second_cnt_in;
   logic               dropped_ff, dropped_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]   np_ff, np_in;
   logic [CNT_W-1:0]   span_ff, span_in;
   logic               swap_ff, swap_in;
   logic               empty_ff, empty_in;
   logic               ovf_ff, ovf_in;
   logic [CNT_W-1:0]   i_ff, i_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic [DRAIN_W-1:0] drain_ff, drain_in;

   logic             accept, is_first, first_full, second_full, trigger;
   logic [CNT_W-1:0] second_after, np_new, nw_new, win_addr;
   logic             swap_new, j_last, i_last, result_free;

   assign accept       = req_tvalid && req_tready;
   assign is_first     = (req_op == OP_FIRST);
   assign first_full   = (first_cnt_ff == CNT_W'(MAX_LEN));
   assign second_full  = (second_cnt_ff == CNT_W'(MAX_LEN));
   assign trigger      = accept && (req_op == OP_SECOND) && req_last;
   assign second_after = second_full ? second_cnt_ff : second_cnt_ff + CNT_W'(1);
   assign swap_new     = (first_cnt_ff > second_after);
   assign np_new       = swap_new ? second_after : first_cnt_ff;
   assign nw_new       = swap_new ? first_cnt_ff : second_after;
   assign j_last       = (j_ff == np_ff - CNT_W'(1));
   assign i_last       = (i_ff == span_ff);
   assign win_addr     = i_ff + j_ff;
   assign result_free  = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (trigger) begin
               state_in = (np_new == '0) ? ST_FINISH : ST_RUN;
            end
         end
         ST_RUN: begin
            if (j_last && i_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_ff == DRAIN_W'(DRAIN_CYCLES - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (result_free) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready          = (state_ff == ST_LOAD);
      cmd.wr_first        = accept && is_first && !first_full;
      cmd.wr_second       = accept && !is_first && !second_full;
      cmd.rd_valid        = (state_ff == ST_RUN);
      cmd.rd_first        = (j_ff == '0);
      cmd.rd_last         = j_last;
      cmd.rd_swap         = swap_ff;
      cmd.clear_best      = trigger;
      cmd.load_result     = (state_ff == ST_FINISH) && result_free;
      cmd.result_zero     = empty_ff;
      cmd.result_overflow = ovf_ff;
      wr_addr             = is_first ? first_cnt_ff[ADDR_W-1:0] : second_cnt_ff[ADDR_W-1:0];
      rd_first_addr       = swap_ff ? win_addr[ADDR_W-1:0] : j_ff[ADDR_W-1:0];
      rd_second_addr      = swap_ff ? j_ff[ADDR_W-1:0] : win_addr[ADDR_W-1:0];
      rsp_tvalid          = rsp_valid_ff;
   end

   // register updates
   always_comb begin
      first_cnt_in  = first_cnt_ff;
      second_cnt_in = second_cnt_ff;
      dropped_in    = dropped_ff;
      np_in         = np_ff;
      span_in       = span_ff;
      swap_in       = swap_ff;
      empty_in      = empty_ff;
      ovf_in        = ovf_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      drain_in      = drain_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (is_first) begin
                  if (first_full) begin
                     dropped_in = 1'b1;
                  end else begin
                     first_cnt_in = first_cnt_ff + CNT_W'(1);
                  end
               end else if (req_last) begin
                  first_cnt_in  = '0;
                  second_cnt_in = '0;
                  dropped_in    = 1'b0;
                  np_in         = np_new;
                  span_in       = nw_new - np_new;
                  swap_in       = swap_new;
                  empty_in      = (np_new == '0);
                  ovf_in        = dropped_ff || second_full;
                  i_in          = '0;
                  j_in          = '0;
               end else begin
                  if (second_full) begin
                     dropped_in = 1'b1;
                  end else begin
                     second_cnt_in = second_cnt_ff + CNT_W'(1);
                  end
               end
            end
         end
         ST_RUN: begin
            drain_in = '0;
            if (j_last) begin
               j_in = '0;
               i_in = i_ff + CNT_W'(1);
            end else begin
               j_in = j_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + DRAIN_W'(1);
         end
         ST_FINISH: begin
            drain_in = '0;
         end
         default: begin
            drain_in = '0;
         end
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         first_cnt_ff  <= '0;
         second_cnt_ff <= '0;
         dropped_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_cnt_ff  <= first_cnt_in;
         second_cnt_ff <= second_cnt_in;
         dropped_ff    <= dropped_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      np_ff    <= np_in;
      span_ff  <= span_in;
      swap_ff  <= swap_in;
      empty_ff <= empty_in;
      ovf_ff   <= ovf_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      drain_ff <= drain_in;
   end

   `ASSERT_IMPLY(a_scan_index_range, clock, reset, state_ff == ST_RUN, (j_ff < np_ff) && (i_ff <= span_ff))
   `ASSERT_IMPLY(a_count_bound, clock, reset, state_ff == ST_LOAD, (first_cnt_ff <= CNT_W'(MAX_LEN)) && (second_cnt_ff <= CNT_W'(MAX_LEN)))
   `ASSERT_NEXT(a_trigger_restarts_load, clock, reset, trigger, (first_cnt_ff == '0) && (second_cnt_ff == '0) && !dropped_ff && (state_ff != ST_LOAD))

endmodule

`default_nettype wire

// ===== src/sliding_min_squared_distance_core.sv =====
// ----------------------------------------------------------------------------
// sliding_min_squared_distance_core
// Minimum summed squared difference of the shorter series slid over the longer.
// ----------------------------------------------------------------------------
// Samples load at one request per cycle between scans: tuser 0 appends to the
// first series, tuser 1 to the second, and a second-series request with tlast
// set starts the scan. Each series holds up to MAX_LEN samples; later ones are
// dropped and reported on rsp_tuser. The scan reads one sample pair per cycle
// from the two sample memories into a single difference, square and accumulate
// pipeline, so after the starting request the block steps through all
// nw - np + 1 alignments of np pairs each (nw, np: longer and shorter length)
// before the result is registered, or skips the scan when a series is empty; no
// requests are taken meanwhile. Loading for the next run continues while a
// result waits on the response side. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module sliding_min_squared_distance_core #(
   parameter int MAX_LEN      = 1024,
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire  logic                                 clock,
   input  wire  logic                                 reset,
   input  wire  logic                                 req_tvalid,
   output logic                                       req_tready,
   input  wire  logic [smsd_pkg::REQ_DATA_W-1:0]      req_tdata,   // [15:0] sample
   input  wire  logic                                 req_tuser,   // [0] operation
   input  wire  logic                                 req_tlast,
   output logic                                       rsp_tvalid,
   input  wire  logic                                 rsp_tready,
   output logic       [smsd_pkg::SUM_WIDTH-1:0]       rsp_tdata,   // [47:0] min_distance
   output logic                                       rsp_tuser,   // [0] overflow
   input  wire  logic                                 csr_psel,
   input  wire  logic                                 csr_penable,
   input  wire  logic                                 csr_pwrite,
   input  wire  logic [smsd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire  logic [smsd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic       [smsd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                       csr_pready
);
   import smsd_pkg::*;

   localparam int ADDR_W = $clog2(MAX_LEN);

   dp_cmd_type                   cmd;
   logic [ADDR_W-1:0]            wr_addr, rd_first_addr, rd_second_addr;
   logic                         centred_mode;
   logic [SAMPLE_WIDTH+REQ_DATA_W-1:0] raw_ext;
   logic [SAMPLE_WIDTH-1:0]      sample;

   assign raw_ext = {{SAMPLE_WIDTH{1'b0}}, req_tdata};
   assign sample  = raw_ext[SAMPLE_WIDTH-1:0];

   smsd_regs u_regs (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .centred_mode (centred_mode)
   );

   smsd_ctrl #(
      .MAX_LEN (MAX_LEN)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_op         (req_tuser),
      .req_last       (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .cmd            (cmd),
      .wr_addr        (wr_addr),
      .rd_first_addr  (rd_first_addr),
      .rd_second_addr (rd_second_addr)
   );

   smsd_dp #(
      .MAX_LEN      (MAX_LEN),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .wr_addr        (wr_addr),
      .wr_data        (sample),
      .rd_first_addr  (rd_first_addr),
      .rd_second_addr (rd_second_addr),
      .centred_mode   (centred_mode),
      .min_distance   (rsp_tdata),
      .overflow       (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== tb/sliding_distance_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_distance_checker
// Watches the sample, result and register ports of the sliding minimum
// squared distance core, keeps its own copy of both series and the mode,
// and compares every result and every mode register read with its own prediction.
// ----------------------------------------------------------------------------
module sliding_distance_checker
   import smsd_pkg::*;
#(
   parameter int MAX_LEN = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [SUM_WIDTH-1:0]  rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int                    error_count,
   output int                    pending_count,
   output int                    result_count
);

   typedef struct packed {
      logic [SUM_WIDTH-1:0] distance;
      logic                 overflow;
   } distance_result_type;

   int                  first_samples [MAX_LEN];
   int                  second_samples[MAX_LEN];
   int                  first_len;
   int                  second_len;
   logic                dropped;
   logic                centred;
   distance_result_type expected_distances[$];
   distance_result_type oldest;
   int                  errors;
   int                  results;

   initial begin
      errors  = 0;
      results = 0;
   end

   function automatic int series_sample(bit from_first, int idx);
      return from_first ? first_samples[idx] : second_samples[idx];
   endfunction

   function automatic logic [SUM_WIDTH-1:0] predict_min_distance();
      bit          pat_first;
      int          np;
      int          nw;
      longint      off;
      longint      d;
      logic [63:0] limit;
      logic [63:0] best;
      logic [63:0] sum;
      logic [63:0] sq;
      limit     = 64'(SUM_MAX);
      pat_first = (first_len <= second_len);
      np        = pat_first ? first_len : second_len;
      nw        = pat_first ? second_len : first_len;
      if (np == 0) begin
         return '0;
      end
      best = limit;
      for (int i = 0; i <= nw - np; i++) begin
         off = 0;
         if (centred) begin
            off = longint'(series_sample(!pat_first, i)) - longint'(series_sample(pat_first, 0));
         end
         sum = '0;
         for (int j = 0; j < np; j++) begin
            d = longint'(series_sample(!pat_first, i + j))
                - longint'(series_sample(pat_first, j)) - off;
            if (d < 0) begin
               d = -d;
            end
            sq = 64'(d * d);
            if (sq >= limit - sum) begin
               sum = limit;
               break;
            end
            sum = sum + sq;
         end
         if (sum < best) begin
            best = sum;
         end
         if (best == 0) begin
            break;
         end
      end
      return best[SUM_WIDTH-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         first_len  = 0;
         second_len = 0;
         dropped    = 1'b0;
         centred    = 1'b0;
         expected_distances.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr == CSR_CENTRED_ADDR) begin
            if (csr_pwrite) begin
               centred = csr_pwdata[0];
            end else if (csr_prdata !== CSR_DATA_W'(centred)) begin
               errors++;
               $error("centred_mode readback: expected %0d, actual %0h", centred, csr_prdata);
            end
         end

         if (rsp_tvalid && rsp_tready) begin
            if (expected_distances.size() == 0) begin
               errors++;
               $error("unexpected result: min_distance %0d overflow %0d", rsp_tdata, rsp_tuser);
            end else begin
               oldest = expected_distances.pop_front();
               results++;
               if (rsp_tdata !== oldest.distance) begin
                  errors++;
                  $error("min_distance: expected %0d, actual %0d", oldest.distance, rsp_tdata);
               end
               if (rsp_tuser !== oldest.overflow) begin
                  errors++;
                  $error("overflow: expected %0d, actual %0d", oldest.overflow, rsp_tuser);
               end
            end
         end

         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_FIRST) begin
               if (first_len < MAX_LEN) begin
                  first_samples[first_len] = int'($signed(req_tdata));
                  first_len++;
               end else begin
                  dropped = 1'b1;
               end
            end else begin
               if (second_len < MAX_LEN) begin
                  second_samples[second_len] = int'($signed(req_tdata));
                  second_len++;
               end else begin
                  dropped = 1'b1;
               end
               if (req_tlast) begin
                  expected_distances.push_back('{distance: predict_min_distance(),
                                                 overflow: dropped});
                  first_len  = 0;
                  second_len = 0;
                  dropped    = 1'b0;
               end
            end
         end
      end
      error_count   <= errors;
      pending_count <= expected_distances.size();
      result_count  <= results;
   end

endmodule

// ===== tb/sliding_min_squared_distance_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_min_squared_distance_core_test
// Loads sample series into the core, directed corner cases first, then random
// loads of mixed shape under both distance modes and one load past capacity,
// with random stalls on both streams; the checker judges every result.
// ----------------------------------------------------------------------------
module sliding_min_squared_distance_core_test;
   import smsd_pkg::*;

   localparam int MAX_LEN       = 1024;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int HOLD_OFF      = 16;
   localparam int PHASES        = 6;
   localparam int PHASE_SAMPLES = 100;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tuser   = OP_FIRST;
   logic                  req_tlast   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [SUM_WIDTH-1:0]  rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int error_count;
   int pending_count;
   int result_count;
   int cycle_count   = 0;
   int sent_count    = 0;
   int load_count    = 0;
   int random_sent   = 0;
   bit no_stall      = 1'b0;

   sliding_min_squared_distance_core #(
      .MAX_LEN      (MAX_LEN),
      .SAMPLE_WIDTH (16)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),     // [15:0] sample
      .req_tuser   (req_tuser),     // [0] operation
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),     // [47:0] min_distance
      .rsp_tuser   (rsp_tuser),     // [0] overflow
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   sliding_distance_checker #(
      .MAX_LEN (MAX_LEN)
   ) checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .error_count   (error_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side: random stall before each result, none while no_stall is set
   initial begin
      int gap;
      @(posedge clock);
      forever begin
         gap = no_stall ? 0 : $urandom_range(0, 11);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_req(input logic op, input logic [REQ_DATA_W-1:0] smp, input logic lst);
      int gap;
      gap = no_stall ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= smp;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      sent_count++;
      if (op == OP_SECOND && lst) begin
         load_count++;
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   // write the mode with junk in the unused bits, then read it back
   task automatic write_centred_mode(input logic mode);
      logic [CSR_DATA_W-1:0] data;
      data    = $urandom;
      data[0] = mode;
      drain_results();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_CENTRED_ADDR;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [REQ_DATA_W-1:0] random_sample(int flavor);
      case (flavor)
         0: return REQ_DATA_W'($urandom);
         1: begin
            case ($urandom_range(0, 3))
               0:       return 16'h8000;
               1:       return 16'h7fff;
               2:       return 16'h0000;
               default: return 16'hffff;
            endcase
         end
         2:       return REQ_DATA_W'(int'($urandom_range(0, 8)) - 4);
         default: return REQ_DATA_W'(int'($urandom_range(0, 200)) - 100);
      endcase
   endfunction

   task automatic run_random_load();
      logic [REQ_DATA_W-1:0] first_vals[$];
      logic [REQ_DATA_W-1:0] second_vals[$];
      logic [REQ_DATA_W-1:0] v;
      int                    first_len;
      int                    second_len;
      int                    flavor;
      int                    k;
      int                    off;
      bit                    interleave;
      bit                    mark_end;
      bit                    take_first;
      no_stall = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 19) < 17) begin
         first_len  = $urandom_range(0, 12);
         second_len = $urandom_range(1, 12);
      end else begin
         first_len  = $urandom_range(0, 48);
         second_len = $urandom_range(1, 48);
      end
      flavor = $urandom_range(0, 3);
      for (int i = 0; i < first_len; i++) first_vals.push_back(random_sample(flavor));
      for (int i = 0; i < second_len; i++) second_vals.push_back(random_sample(flavor));
      // plant the shorter series inside the longer one, maybe shifted
      if (first_len > 0 && $urandom_range(0, 3) == 0) begin
         off = ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, 40)) - 20;
         if (first_len <= second_len) begin
            k = $urandom_range(0, second_len - first_len);
            for (int j = 0; j < first_len; j++) first_vals[j] = second_vals[k + j] + 16'(off);
         end else begin
            k = $urandom_range(0, first_len - second_len);
            for (int j = 0; j < second_len; j++) second_vals[j] = first_vals[k + j] + 16'(off);
         end
      end
      interleave = ($urandom_range(0, 4) == 0);
      mark_end   = $urandom_range(0, 1);
      random_sent += first_len + second_len;
      while (first_vals.size() + second_vals.size() != 0) begin
         take_first = first_vals.size() != 0 &&
                      (!interleave || second_vals.size() == 1 || $urandom_range(0, 1) == 1);
         if (take_first) begin
            v = first_vals.pop_front();
            send_req(OP_FIRST, v,
                     interleave ? 1'($urandom_range(0, 1)) : (mark_end && first_vals.size() == 0));
         end else begin
            v = second_vals.pop_front();
            send_req(OP_SECOND, v, second_vals.size() == 0);
         end
      end
   endtask

   // second series past capacity, the trigger sample itself dropped
   task automatic run_capacity_load();
      int flavor;
      no_stall = 1'b0;
      flavor   = $urandom_range(0, 3);
      send_req(OP_FIRST, random_sample(flavor), 1'b0);
      send_req(OP_FIRST, random_sample(flavor), 1'b1);
      for (int i = 0; i < MAX_LEN + 2; i++) begin
         send_req(OP_SECOND, random_sample(flavor), i == MAX_LEN + 1);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty first series
      send_req(OP_SECOND, 16'd7, 1'b1);
      // end-of-first marker, extremes, equal lengths
      send_req(OP_FIRST, 16'h8000, 1'b1);
      send_req(OP_FIRST, 16'h7fff, 1'b0);
      send_req(OP_SECOND, 16'h7fff, 1'b0);
      send_req(OP_SECOND, 16'h8000, 1'b1);
      // first series longer than second
      send_req(OP_FIRST, 16'd10, 1'b0);
      send_req(OP_FIRST, 16'd20, 1'b0);
      send_req(OP_FIRST, 16'd30, 1'b0);
      send_req(OP_FIRST, 16'd40, 1'b0);
      send_req(OP_FIRST, 16'd50, 1'b1);
      send_req(OP_SECOND, 16'd21, 1'b0);
      send_req(OP_SECOND, 16'd33, 1'b1);
      // exact match inside the window
      send_req(OP_FIRST, 16'd3, 1'b0);
      send_req(OP_FIRST, 16'd4, 1'b0);
      send_req(OP_SECOND, 16'd1, 1'b0);
      send_req(OP_SECOND, 16'd3, 1'b0);
      send_req(OP_SECOND, 16'd4, 1'b0);
      send_req(OP_SECOND, 16'd9, 1'b1);
      // largest differences
      send_req(OP_FIRST, 16'h8000, 1'b0);
      send_req(OP_SECOND, 16'h7fff, 1'b0);
      send_req(OP_SECOND, 16'h8000, 1'b0);
      send_req(OP_SECOND, 16'h7fff, 1'b1);

      for (int phase = 0; phase < PHASES; phase++) begin
         write_centred_mode(phase % 2 == 0);
         if (phase == 2) begin
            run_capacity_load();
         end
         while (random_sent < (phase + 1) * PHASE_SAMPLES) run_random_load();
      end

      no_stall = 1'b0;
      drain_results();
      $display("Sent %0d samples in %0d loads, both distance modes, one load past capacity.",
               sent_count, load_count);
      $display("Compared %0d distance results.", result_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sliding_min_squared_distance_core.f =====
+incdir+src
src/smsd_pkg.sv
src/smsd_regs.sv
src/smsd_dp.sv
src/smsd_ctrl.sv
src/sliding_min_squared_distance_core.sv
tb/sliding_distance_checker.sv
tb/sliding_min_squared_distance_core_test.sv
